// ===== hdl/page_allocation_bitmap_defines.svh =====
// Assertion macros shared by the page allocation bitmap checkers.
`ifndef PAGE_ALLOCATION_BITMAP_DEFINES_SVH
`define PAGE_ALLOCATION_BITMAP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge and disabled during reset.
`define PAB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and disabled during reset.
`define PAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pab_pkg.sv =====
// Shared types, constants and word-search helpers for the page allocation bitmap.
`default_nettype none

package pab_pkg;

	localparam int MAX_PAGES_DEF = 4096;
	localparam int WORD_BITS     = 64;
	localparam int WORD_SEL      = 6;
	localparam int OP_W          = 2;
	localparam int PAGE_W        = 12;
	localparam int ST_W          = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 2'd0,
		OP_DISPOSE  = 2'd1,
		OP_NEXT     = 2'd2,
		OP_VALIDATE = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_EOF     = 2'd3
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_req;
		logic decide;
		logic scan;
		logic tread;
		logic tcheck;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		op_t  op;
		logic range_bad;
		logic next_empty;
		logic pif_zero;
		logic scan_hit;
		logic scan_end;
		logic map_full;
	} stat_t;

	// Isolate the lowest set bit of a map word
	function automatic logic [WORD_BITS-1:0] lowest_one(input logic [WORD_BITS-1:0] x);
		return x & (~x + WORD_BITS'(1));
	endfunction

	// Encode a one-hot map word into its bit position
	function automatic logic [WORD_SEL-1:0] onehot_index(input logic [WORD_BITS-1:0] x);
		logic [WORD_SEL-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (x[i]) begin
				idx = idx | WORD_SEL'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/pab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pab_ram #(
	parameter int WIDTH = pab_pkg::WORD_BITS,
	parameter int DEPTH = pab_pkg::MAX_PAGES_DEF / pab_pkg::WORD_BITS
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on request, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/pab_datapath.sv =====
// Datapath: page map RAM, row valid bits, counters, word search and result registers.
`default_nettype none

module pab_datapath #(
	parameter int MAX_PAGES = pab_pkg::MAX_PAGES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pab_pkg::cmd_t                 cmd,
	output pab_pkg::stat_t                     stat,
	input  wire logic [pab_pkg::OP_W-1:0]      operation,
	input  wire logic [pab_pkg::PAGE_W-1:0]    page_number,
	output logic      [pab_pkg::ST_W-1:0]      status,
	output logic      [pab_pkg::PAGE_W-1:0]    result_page,
	output logic      [pab_pkg::PAGE_W-1:0]    page_count,
	output logic      [pab_pkg::PAGE_W-1:0]    allocated_count
);

	localparam int WB    = pab_pkg::WORD_BITS;
	localparam int BW    = pab_pkg::WORD_SEL;
	localparam int DEPTH = MAX_PAGES / WB;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = $clog2(MAX_PAGES);
	localparam int EW    = ((PW > pab_pkg::PAGE_W) ? PW : pab_pkg::PAGE_W) + 1;
	localparam logic [PW-1:0] LAST_PAGE = PW'(MAX_PAGES - 1);

	// Request and search registers
	pab_pkg::op_t             op_q;
	logic [pab_pkg::PAGE_W-1:0] page_q;
	logic [PW-1:0]            pif_q;
	logic [PW-1:0]            pal_q;
	logic [PW-1:0]            lo_q;
	logic [PW-1:0]            tgt_q;
	logic [AW:0]              ptr_q;
	logic                     rdv_s1;
	logic [AW-1:0]            rw_s1;
	logic                     rv_s1;
	logic [DEPTH-1:0]         row_valid_q;
	pab_pkg::status_t         res_status_q;
	logic [PW-1:0]            res_page_q;
	logic [pab_pkg::ST_W-1:0]   out_status_q;
	logic [pab_pkg::PAGE_W-1:0] out_page_q;
	logic [pab_pkg::PAGE_W-1:0] out_pc_q;
	logic [pab_pkg::PAGE_W-1:0] out_ac_q;

	// Combinational signals
	logic [EW-1:0] page_ext;
	logic [EW-1:0] pif_ext;
	logic          range_bad;
	logic          next_empty;
	logic          map_full;
	logic [PW-1:0] lo_new;
	logic [AW-1:0] lo_word;
	logic [AW-1:0] lo_new_word;
	logic [AW-1:0] hi_word;
	logic [AW-1:0] tgt_word;
	logic [BW-1:0] lo_bit;
	logic [BW-1:0] hi_bit;
	logic [BW-1:0] tgt_bit;
	logic [AW-1:0] rd_addr;
	logic          issue;
	logic [WB-1:0] rdata;
	logic [WB-1:0] eff;
	logic [WB-1:0] lo_mask;
	logic [WB-1:0] hi_mask;
	logic [WB-1:0] cand;
	logic [WB-1:0] cand_one;
	logic          hit;
	logic [PW-1:0] found;
	logic          scan_hit;
	logic          scan_end;
	logic [WB-1:0] tgt_one;
	logic          tgt_set;
	logic          we;
	logic [AW-1:0] waddr;
	logic [WB-1:0] wdata;

	// Range checks on the held request
	assign page_ext   = EW'(page_q);
	assign pif_ext    = EW'(pif_q);
	assign range_bad  = (page_q == '0) || (page_ext > pif_ext);
	assign next_empty = (page_ext >= pif_ext);
	assign map_full   = (pif_q == LAST_PAGE);

	// Search bounds and word addresses
	assign lo_new      = (op_q == pab_pkg::OP_ALLOC) ? PW'(1) : PW'(page_ext + EW'(1));
	assign lo_new_word = AW'({1'b0, lo_new} >> BW);
	assign lo_word     = AW'({1'b0, lo_q} >> BW);
	assign hi_word     = AW'({1'b0, pif_q} >> BW);
	assign tgt_word    = AW'({1'b0, tgt_q} >> BW);
	assign lo_bit      = lo_q[BW-1:0];
	assign hi_bit      = pif_q[BW-1:0];
	assign tgt_bit     = tgt_q[BW-1:0];

	assign rd_addr = cmd.tread ? tgt_word : ptr_q[AW-1:0];
	assign issue   = (ptr_q <= {1'b0, hi_word});

	// Rows never written read as all free
	assign eff = rdata & {WB{rv_s1}};

	// Search one word: free bits for allocate, used bits for find-next
	assign lo_mask  = (rw_s1 == lo_word) ? ({WB{1'b1}} << lo_bit) : {WB{1'b1}};
	assign hi_mask  = (rw_s1 == hi_word) ? ({WB{1'b1}} >> (BW'(WB - 1) - hi_bit))
		: {WB{1'b1}};
	assign cand     = ((op_q == pab_pkg::OP_ALLOC) ? ~eff : eff) & lo_mask & hi_mask;
	assign cand_one = pab_pkg::lowest_one(cand);
	assign hit      = |cand;
	assign found    = PW'({rw_s1, pab_pkg::onehot_index(cand_one)});
	assign scan_hit = rdv_s1 & hit;
	assign scan_end = rdv_s1 & ~hit & ~issue;

	// Single-page check
	assign tgt_one = {{(WB-1){1'b0}}, 1'b1} << tgt_bit;
	assign tgt_set = |(eff & tgt_one);

	// Map write: set on allocate, clear on dispose
	assign we = (cmd.scan & scan_hit & (op_q == pab_pkg::OP_ALLOC))
		| (cmd.tcheck & ((op_q == pab_pkg::OP_ALLOC)
		| ((op_q == pab_pkg::OP_DISPOSE) & tgt_set)));
	assign waddr = cmd.scan ? rw_s1 : tgt_word;
	assign wdata = cmd.scan ? (eff | cand_one)
		: ((op_q == pab_pkg::OP_DISPOSE) ? (eff & ~tgt_one) : (eff | tgt_one));

	pab_ram #(
		.WIDTH (WB),
		.DEPTH (DEPTH)
	) u_map_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// Status to the controller
	always_comb begin
		stat.op         = op_q;
		stat.range_bad  = range_bad;
		stat.next_empty = next_empty;
		stat.pif_zero   = (pif_q == '0);
		stat.scan_hit   = scan_hit;
		stat.scan_end   = scan_end;
		stat.map_full   = map_full;
	end

	// Hold counters, row valid bits and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pif_q       <= '0;
			pal_q       <= '0;
			row_valid_q <= '0;
			rdv_s1      <= 1'b0;
			ptr_q       <= '0;
		end else begin
			rdv_s1 <= cmd.scan & issue;
			if (we) begin
				row_valid_q[waddr] <= 1'b1;
			end
			if (cmd.decide) begin
				ptr_q <= (AW+1)'(lo_new_word);
			end else if (cmd.scan && issue) begin
				ptr_q <= ptr_q + (AW+1)'(1);
			end
			if (cmd.scan && scan_hit && (op_q == pab_pkg::OP_ALLOC)) begin
				pal_q <= pal_q + PW'(1);
			end else if (cmd.tcheck) begin
				case (op_q)
					pab_pkg::OP_ALLOC: begin
						pif_q <= pif_q + PW'(1);
						pal_q <= pal_q + PW'(1);
					end
					pab_pkg::OP_DISPOSE: begin
						if (tgt_set) begin
							pal_q <= pal_q - PW'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Capture the request, track the read pipeline and build the result
	always_ff @(posedge clk) begin
		rv_s1 <= row_valid_q[rd_addr];
		if (cmd.scan) begin
			rw_s1 <= ptr_q[AW-1:0];
		end
		if (cmd.load_req) begin
			op_q   <= pab_pkg::op_t'(operation);
			page_q <= page_number;
		end
		if (cmd.decide) begin
			lo_q       <= lo_new;
			tgt_q      <= (op_q == pab_pkg::OP_ALLOC) ? (pif_q + PW'(1)) : PW'(page_q);
			res_page_q <= '0;
			res_status_q <= (op_q == pab_pkg::OP_NEXT) ? pab_pkg::ST_EOF
				: pab_pkg::ST_INVALID;
		end
		if (cmd.scan && scan_hit) begin
			res_status_q <= pab_pkg::ST_OK;
			res_page_q   <= found;
		end else if (cmd.scan && scan_end && (op_q == pab_pkg::OP_ALLOC) && map_full) begin
			res_status_q <= pab_pkg::ST_FULL;
		end
		if (cmd.tcheck) begin
			case (op_q)
				pab_pkg::OP_ALLOC: begin
					res_status_q <= pab_pkg::ST_OK;
					res_page_q   <= tgt_q;
				end
				pab_pkg::OP_DISPOSE: begin
					res_status_q <= tgt_set ? pab_pkg::ST_OK : pab_pkg::ST_INVALID;
				end
				default: begin
					res_status_q <= tgt_set ? pab_pkg::ST_OK : pab_pkg::ST_INVALID;
					res_page_q   <= tgt_set ? tgt_q : '0;
				end
			endcase
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_page_q   <= pab_pkg::PAGE_W'(res_page_q);
			out_pc_q     <= pab_pkg::PAGE_W'(pif_q);
			out_ac_q     <= pab_pkg::PAGE_W'(pal_q);
		end
	end

	assign status          = out_status_q;
	assign result_page     = out_page_q;
	assign page_count      = out_pc_q;
	assign allocated_count = out_ac_q;

endmodule

`default_nettype wire

// ===== hdl/pab_controller.sv =====
// Controller: sequences one request through decide, word scan, page check and result.
`default_nettype none

module pab_controller (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire pab_pkg::stat_t stat,
	output pab_pkg::cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_TREAD,
		S_TCHECK,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	// Result slot is free when empty or being taken
	assign slot_free = !out_valid_q || !out_stall;

	// Decode commands from the current state
	always_comb begin
		cmd.load_req = (state_q == S_IDLE) && in_valid;
		cmd.decide   = (state_q == S_DECIDE);
		cmd.scan     = (state_q == S_SCAN);
		cmd.tread    = (state_q == S_TREAD);
		cmd.tcheck   = (state_q == S_TCHECK);
		cmd.load_out = (state_q == S_FINISH) && slot_free;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Advance the sequence and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					unique case (stat.op) inside
						pab_pkg::OP_ALLOC: begin
							state_q <= stat.pif_zero ? S_TREAD : S_SCAN;
						end
						pab_pkg::OP_NEXT: begin
							state_q <= stat.next_empty ? S_FINISH : S_SCAN;
						end
						pab_pkg::OP_DISPOSE, pab_pkg::OP_VALIDATE: begin
							state_q <= stat.range_bad ? S_FINISH : S_TREAD;
						end
					endcase
				end
				S_SCAN: begin
					if (stat.scan_hit) begin
						state_q <= S_FINISH;
					end else if (stat.scan_end) begin
						state_q <= ((stat.op == pab_pkg::OP_ALLOC) && !stat.map_full)
							? S_TREAD : S_FINISH;
					end
				end
				S_TREAD: begin
					state_q <= S_TCHECK;
				end
				S_TCHECK: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/page_allocation_bitmap.sv =====
// Top level of the page allocation bitmap: controller, datapath and port wiring.
// One request at a time. The allocation map sits in a RAM of 64-bit words
// (MAX_PAGES/64 rows) with one valid flip-flop per row, so reset clears the map
// at once and no clearing pass is needed. Allocate and find-next scan the map
// one word per cycle through the RAM read port, and an allocate that extends
// the file adds a read-modify-write of the new page's word. An allocate on an
// empty file goes straight to that read-modify-write, as do dispose and
// validate; a dispose or validate of a page outside the file, and a find-next
// that starts at or past the last page, go straight to the result. A new request
// is taken while the previous result still waits in the output register; the
// block finishes it once that register frees.
`default_nettype none

module page_allocation_bitmap #(
	parameter int MAX_PAGES = pab_pkg::MAX_PAGES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [pab_pkg::OP_W-1:0]   operation,
	input  wire logic [pab_pkg::PAGE_W-1:0] page_number,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [pab_pkg::ST_W-1:0]   status,
	output logic      [pab_pkg::PAGE_W-1:0] result_page,
	output logic      [pab_pkg::PAGE_W-1:0] page_count,
	output logic      [pab_pkg::PAGE_W-1:0] allocated_count
);

	pab_pkg::cmd_t  cmd;
	pab_pkg::stat_t stat;

	pab_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pab_datapath #(
		.MAX_PAGES (MAX_PAGES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.operation       (operation),
		.page_number     (page_number),
		.status          (status),
		.result_page     (result_page),
		.page_count      (page_count),
		.allocated_count (allocated_count)
	);

endmodule

`default_nettype wire

// ===== hdl/pab_checker.sv =====
// Port-level checker for the page allocation bitmap, bound to the top level.
`default_nettype none
`include "page_allocation_bitmap_defines.svh"

module pab_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [pab_pkg::ST_W-1:0]   status,
	input wire logic [pab_pkg::PAGE_W-1:0] result_page,
	input wire logic [pab_pkg::PAGE_W-1:0] page_count,
	input wire logic [pab_pkg::PAGE_W-1:0] allocated_count
);

	// One request in progress at a time
	`PAB_ASSERT_NEXT(a_busy_after_request, clk, arst_n,
		in_valid && !in_stall, in_stall,
		"request taken while another is in progress")

	// Failed requests report no page
	`PAB_ASSERT_NOW(a_zero_page_on_error, clk, arst_n,
		out_valid && (status != pab_pkg::ST_OK), result_page == '0,
		"nonzero page with error status")

	// Allocated pages never outnumber pages in the file
	`PAB_ASSERT_NOW(a_count_order, clk, arst_n,
		out_valid, allocated_count <= page_count,
		"allocated count above page count")

	// Stalled result holds
	`PAB_ASSERT_NEXT(a_result_hold, clk, arst_n,
		out_valid && out_stall,
		out_valid && $stable(status) && $stable(result_page)
			&& $stable(page_count) && $stable(allocated_count),
		"stalled result changed")

endmodule

bind page_allocation_bitmap pab_checker u_pab_checker (.*);

`default_nettype wire

// ===== sim/tb_page_allocation_bitmap.sv =====
// Self-checking testbench for the page allocation bitmap, with driver, monitor and page-map predictor.
`timescale 1ns / 100ps

module tb_page_allocation_bitmap;
	import pab_pkg::*;

	localparam int MAP_PAGES = MAX_PAGES_DEF;

	typedef struct packed {
		op_t               op;
		logic [PAGE_W-1:0] page;
	} page_req_t;

	typedef struct packed {
		status_t           st;
		logic [PAGE_W-1:0] page;
		logic [PAGE_W-1:0] pages;
		logic [PAGE_W-1:0] live;
	} page_answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [OP_W-1:0]   operation = OP_ALLOC;
	logic [PAGE_W-1:0] page_number = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ST_W-1:0]   status;
	logic [PAGE_W-1:0] result_page;
	logic [PAGE_W-1:0] page_count;
	logic [PAGE_W-1:0] allocated_count;

	// Predicted page map and counters
	bit map_bits [MAP_PAGES];
	int file_pages = 0;
	int live_pages = 0;

	page_req_t    pending [$];
	page_answer_t results_due [$];

	int          mismatches = 0;
	int          results_seen = 0;
	int          gap_left = 0;
	int          burst_left = 0;
	int unsigned gap_roll;
	int          stall_left = 0;
	int          calm_left = 0;
	int          next_long_hold = 150;
	int unsigned stall_roll;

	page_allocation_bitmap dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.page_number     (page_number),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.result_page     (result_page),
		.page_count      (page_count),
		.allocated_count (allocated_count)
	);

	always #10 clk = ~clk;

	// True when the page lies within the file and is allocated
	function automatic bit page_in_use(input logic [PAGE_W-1:0] pg);
		return int'(pg) >= 1 && int'(pg) <= file_pages && map_bits[pg];
	endfunction

	// Apply one request to the predicted map and return its answer
	function automatic page_answer_t answer_request(input op_t op, input logic [PAGE_W-1:0] pg);
		page_answer_t a;
		int i;
		a.st = ST_OK;
		a.page = '0;
		case (op)
			OP_ALLOC: begin
				i = 1;
				while (i <= file_pages && i < MAP_PAGES && map_bits[i])
					i++;
				if (i >= MAP_PAGES) begin
					a.st = ST_FULL;
				end else begin
					if (i > file_pages)
						file_pages++;
					live_pages++;
					map_bits[i] = 1'b1;
					a.page = PAGE_W'(i);
				end
			end
			OP_DISPOSE: begin
				if (!page_in_use(pg)) begin
					a.st = ST_INVALID;
				end else begin
					map_bits[pg] = 1'b0;
					live_pages--;
				end
			end
			OP_NEXT: begin
				a.st = ST_EOF;
				for (i = int'(pg) + 1; i <= file_pages && i < MAP_PAGES; i++) begin
					if (map_bits[i]) begin
						a.st = ST_OK;
						a.page = PAGE_W'(i);
						break;
					end
				end
			end
			default: begin
				if (!page_in_use(pg))
					a.st = ST_INVALID;
				else
					a.page = pg;
			end
		endcase
		a.pages = PAGE_W'(file_pages);
		a.live = PAGE_W'(live_pages);
		return a;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns, result %0d: %s", $time, results_seen, what);
		mismatches++;
	endtask

	// Draw an operation, allocate-heavy so the file keeps growing slowly
	function automatic op_t pick_op();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			return OP_ALLOC;
		else if (roll < 55)
			return OP_DISPOSE;
		else if (roll < 75)
			return OP_NEXT;
		return OP_VALIDATE;
	endfunction

	// Draw a page, mostly inside the file, with edges and noise
	function automatic logic [PAGE_W-1:0] pick_page();
		int unsigned roll;
		int top;
		roll = $urandom_range(0, 99);
		top = (file_pages < 1) ? 1 : file_pages;
		if (roll < 70)
			return PAGE_W'($urandom_range(1, top));
		else if (roll < 78)
			return '0;
		else if (roll < 86)
			return PAGE_W'(file_pages + 1);
		else if (roll < 90)
			return '1;
		return PAGE_W'($urandom_range(0, MAP_PAGES - 1));
	endfunction

	task automatic send(input op_t op, input logic [PAGE_W-1:0] pg);
		page_req_t r;
		while (pending.size() >= 4)
			@(negedge clk);
		r.op = op;
		r.page = pg;
		pending.push_back(r);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending.size() != 0 || in_valid || results_due.size() != 0);
	endtask

	// Driver: predict each accepted request, then offer the next, at times after a random gap
	always @(posedge clk or negedge arst_n) begin : drive
		page_req_t head;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= OP_ALLOC;
			page_number <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				results_due.push_back(answer_request(op_t'(operation), page_number));
			// hold a stalled request as it is
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending.size() != 0) begin
					head = pending.pop_front();
					in_valid <= 1'b1;
					operation <= head.op;
					page_number <= head.page;
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						gap_roll = $urandom_range(0, 99);
						if (gap_roll < 4)
							burst_left <= $urandom_range(10, 60);
						else if (gap_roll < 26)
							gap_left <= $urandom_range(1, 3);
						else if (gap_roll < 30)
							gap_left <= $urandom_range(10, 40);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: short and long hold-offs, calm stretches, and a long block now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			calm_left <= 0;
			next_long_hold <= 150;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (results_seen >= next_long_hold) begin
			out_stall <= 1'b1;
			stall_left <= 300;
			next_long_hold <= next_long_hold + 600;
		end else if (calm_left > 0) begin
			out_stall <= 1'b0;
			calm_left <= calm_left - 1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 4) begin
				out_stall <= 1'b0;
				calm_left <= $urandom_range(20, 150);
			end else if (stall_roll < 24) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(0, 3);
			end else if (stall_roll < 26) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(15, 60);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: check each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch
		page_answer_t want;
		if (!arst_n) begin
			results_seen <= 0;
		end else if (out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = results_due.pop_front();
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, want %0d", status, want.st));
				if (result_page !== want.page)
					report_mismatch($sformatf("result_page %0d, want %0d",
						result_page, want.page));
				if (page_count !== want.pages)
					report_mismatch($sformatf("page_count %0d, want %0d",
						page_count, want.pages));
				if (allocated_count !== want.live)
					report_mismatch($sformatf("allocated_count %0d, want %0d",
						allocated_count, want.live));
			end
			results_seen <= results_seen + 1;
		end
	end

	// Stimulus
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// empty map: invalid pages and searches past the end
		send(OP_VALIDATE, 12'd0);
		send(OP_NEXT, 12'd0);
		send(OP_DISPOSE, 12'd1);
		send(OP_NEXT, 12'd4095);
		// grow the file, then probe its edges
		repeat (4) send(OP_ALLOC, 12'd0);
		send(OP_VALIDATE, 12'd4);
		send(OP_VALIDATE, 12'd5);
		send(OP_VALIDATE, 12'd4095);
		// free a page, then touch it again while free
		send(OP_DISPOSE, 12'd2);
		send(OP_DISPOSE, 12'd2);
		send(OP_VALIDATE, 12'd2);
		send(OP_NEXT, 12'd1);
		send(OP_NEXT, 12'd4);
		send(OP_NEXT, 12'd0);
		// reuse the hole, then extend
		send(OP_ALLOC, 12'd4095);
		send(OP_ALLOC, 12'd0);
		send(OP_DISPOSE, 12'd0);
		send(OP_DISPOSE, 12'd4095);
		send(OP_NEXT, 12'd2);
		send(OP_VALIDATE, 12'd1);
		wait_drained();

		// random traffic on a small file, pausing once midway
		for (int n = 0; n < 680; n++) begin
			if (n == 340)
				wait_drained();
			send(pick_op(), pick_page());
		end
		wait_drained();

		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#80_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pab_pkg.sv
hdl/pab_ram.sv
hdl/pab_datapath.sv
hdl/pab_controller.sv
hdl/page_allocation_bitmap.sv
hdl/pab_checker.sv
sim/tb_page_allocation_bitmap.sv
